### src/bounded_deque_with_index_read_unit_assert.svh
// assertion macros used by the deque top-level rtl
`ifndef BOUNDED_DEQUE_WITH_INDEX_READ_UNIT_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_INDEX_READ_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// plain property check on the rising clock, off during reset
`define DQIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// overlapping implication check
`define DQIR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication check
`define DQIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DQIR_ASSERT(lbl, prop, msg)
`define DQIR_ASSERT_IMPL(lbl, ante, cons, msg)
`define DQIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/dqir_pkg.sv
package dqir_pkg;

  localparam int WordW    = 32;
  localparam int OpW      = 3;
  localparam int PosW     = 8;
  localparam int StatW    = 2;
  localparam int DefDepth = 32;

  // operation codes
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_READ_ALL   = 3'd2;
  localparam logic [OpW-1:0] OP_READ_INDEX = 3'd3;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd4;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd5;
  localparam logic [OpW-1:0] OP_CLEAR      = 3'd6;

  // status codes
  localparam logic [StatW-1:0] STAT_OK        = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY     = 2'd1;
  localparam logic [StatW-1:0] STAT_NOT_FOUND = 2'd2;
  localparam logic [StatW-1:0] STAT_FULL      = 2'd3;

  // what every cell of the chain does this cycle
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_ROTATE,
    CELL_APPEND
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [WordW-1:0]   value;
  } cell_ctrl_t;

endpackage

### src/dqir_cell.sv
module dqir_cell #(
  parameter int DEPTH = dqir_pkg::DefDepth,
  parameter int INDEX = 0
) (
  input  logic                                clk_i,
  input  dqir_pkg::cell_ctrl_t                ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]          count_i,
  input  logic signed [dqir_pkg::WordW-1:0]   left_i,
  input  logic signed [dqir_pkg::WordW-1:0]   right_i,
  input  logic signed [dqir_pkg::WordW-1:0]   front_i,
  output logic signed [dqir_pkg::WordW-1:0]   word_o
);

  localparam int CntW = $clog2(DEPTH+1);

  logic signed [dqir_pkg::WordW-1:0] word_q, word_d;
  logic is_tail, is_free, below_tail;

  // position of this cell against the live length
  assign is_tail    = (CntW'(INDEX + 1) == count_i);
  assign is_free    = (CntW'(INDEX) == count_i);
  assign below_tail = (CntW'(INDEX + 1) < count_i);

  // next word
  always_comb begin
    word_d = word_q;
    case (ctrl_i.op)
      dqir_pkg::CELL_HOLD:      word_d = word_q;
      dqir_pkg::CELL_SHIFT_IN:  word_d = left_i;
      dqir_pkg::CELL_SHIFT_OUT: word_d = right_i;
      dqir_pkg::CELL_ROTATE: begin
        if (is_tail) begin
          word_d = front_i;
        end else if (below_tail) begin
          word_d = right_i;
        end
      end
      dqir_pkg::CELL_APPEND: begin
        if (is_free) begin
          word_d = ctrl_i.value;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

### src/bounded_deque_with_index_read_unit.sv
// channel | direction | handshake                | payload
// input   | in        | in_valid_i / in_ready_o  | op_i, value_i, position_i
// output  | out       | out_valid_o / out_ready_i| word_o, status_o, last_o
//
// pushes, pop front, clear and error cases update the deque and load the
// output register when the item is taken; the result sits there until taken.
// read all, read index and pop back rotate the cell chain once through its
// live words, one step a cycle, since the chain has a single front read
// point; each step waits while the output register is full.
// reset (rst_ni low, asynchronous) empties the deque; stored words keep no reset.
// input is not taken during a rotation or while a result is stalled.
module bounded_deque_with_index_read_unit #(
  parameter int DEPTH = dqir_pkg::DefDepth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [dqir_pkg::OpW-1:0]            op_i,
  input  logic signed [dqir_pkg::WordW-1:0]   value_i,
  input  logic [dqir_pkg::PosW-1:0]           position_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dqir_pkg::WordW-1:0]   word_o,
  output logic [dqir_pkg::StatW-1:0]          status_o,
  output logic                                last_o
);

  `include "bounded_deque_with_index_read_unit_assert.svh"

  localparam int CntW = $clog2(DEPTH+1);
  localparam int IdxW = $clog2(DEPTH);
  localparam int PosW = dqir_pkg::PosW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_ROT  = 1'b1;

  logic                         state_q, state_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [IdxW-1:0]              step_q, step_d;
  logic [dqir_pkg::OpW-1:0]     op_q, op_d;
  logic [PosW-1:0]              pos_q, pos_d;

  logic                         out_valid_q, out_valid_d;
  logic signed [dqir_pkg::WordW-1:0] word_q, word_d;
  logic [dqir_pkg::StatW-1:0]   status_q, status_d;
  logic                         last_q, last_d;

  dqir_pkg::cell_ctrl_t         cell_ctrl;
  logic signed [dqir_pkg::WordW-1:0] cell_word [DEPTH];

  logic in_fire, out_free, last_step, is_full, is_empty;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_full    = (count_q == CntW'(DEPTH));
  assign is_empty   = (count_q == '0);
  assign last_step  = (CntW'(step_q) == count_q - CntW'(1));

  // control: decode items and drive the rotation
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    op_d        = op_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q && !out_ready_i;
    word_d      = word_q;
    status_d    = status_q;
    last_d      = last_q;
    cell_ctrl.op    = dqir_pkg::CELL_HOLD;
    cell_ctrl.value = value_i;

    if (state_q == ST_IDLE) begin
      if (in_fire) begin
        out_valid_d = 1'b1;
        word_d      = '0;
        status_d    = dqir_pkg::STAT_OK;
        last_d      = 1'b1;
        case (op_i)
          dqir_pkg::OP_PUSH_FRONT: begin
            if (is_full) begin
              status_d = dqir_pkg::STAT_FULL;
            end else begin
              cell_ctrl.op = dqir_pkg::CELL_SHIFT_IN;
              count_d      = count_q + CntW'(1);
            end
          end
          dqir_pkg::OP_PUSH_BACK: begin
            if (is_full) begin
              status_d = dqir_pkg::STAT_FULL;
            end else begin
              cell_ctrl.op = dqir_pkg::CELL_APPEND;
              count_d      = count_q + CntW'(1);
            end
          end
          dqir_pkg::OP_READ_ALL, dqir_pkg::OP_POP_BACK: begin
            if (is_empty) begin
              status_d = dqir_pkg::STAT_EMPTY;
            end else begin
              out_valid_d = 1'b0;
              state_d     = ST_ROT;
              step_d      = '0;
              op_d        = op_i;
              pos_d       = position_i;
            end
          end
          dqir_pkg::OP_READ_INDEX: begin
            if (is_empty) begin
              status_d = dqir_pkg::STAT_EMPTY;
            end else if (position_i >= PosW'(count_q)) begin
              status_d = dqir_pkg::STAT_NOT_FOUND;
            end else begin
              out_valid_d = 1'b0;
              state_d     = ST_ROT;
              step_d      = '0;
              op_d        = op_i;
              pos_d       = position_i;
            end
          end
          dqir_pkg::OP_POP_FRONT: begin
            if (is_empty) begin
              status_d = dqir_pkg::STAT_EMPTY;
            end else begin
              word_d       = cell_word[0];
              cell_ctrl.op = dqir_pkg::CELL_SHIFT_OUT;
              count_d      = count_q - CntW'(1);
            end
          end
          dqir_pkg::OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
            status_d = dqir_pkg::STAT_OK;
          end
        endcase
      end
    end else if (out_free) begin
      // one rotation step: the front word comes past the read point
      cell_ctrl.op = dqir_pkg::CELL_ROTATE;
      case (op_q)
        dqir_pkg::OP_READ_ALL: begin
          out_valid_d = 1'b1;
          word_d      = cell_word[0];
          status_d    = dqir_pkg::STAT_OK;
          last_d      = last_step;
        end
        dqir_pkg::OP_READ_INDEX: begin
          if (PosW'(step_q) == pos_q) begin
            out_valid_d = 1'b1;
            word_d      = cell_word[0];
            status_d    = dqir_pkg::STAT_OK;
            last_d      = 1'b1;
          end
        end
        dqir_pkg::OP_POP_BACK: begin
          if (last_step) begin
            out_valid_d  = 1'b1;
            word_d       = cell_word[0];
            status_d     = dqir_pkg::STAT_OK;
            last_d       = 1'b1;
            cell_ctrl.op = dqir_pkg::CELL_SHIFT_OUT;
            count_d      = count_q - CntW'(1);
          end
        end
        default: begin
          cell_ctrl.op = dqir_pkg::CELL_ROTATE;
        end
      endcase
      if (last_step) begin
        state_d = ST_IDLE;
        step_d  = '0;
      end else begin
        step_d = step_q + IdxW'(1);
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    pos_q    <= pos_d;
    word_q   <= word_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  // chain of storage cells, cell 0 holds the front word
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [dqir_pkg::WordW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_inner_l
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_inner_r
      assign right_w = cell_word[g+1];
    end
    dqir_cell #(
      .DEPTH (DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .count_i (count_q),
      .left_i  (left_w),
      .right_i (right_w),
      .front_i (cell_word[0]),
      .word_o  (cell_word[g])
    );
  end

  assign out_valid_o = out_valid_q;
  assign word_o      = word_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

  // checks
  `DQIR_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "fill count above depth")
  `DQIR_ASSERT_IMPL(a_step_bound, state_q == ST_ROT, CntW'(step_q) < count_q, "step past live words")
  `DQIR_ASSERT_NEXT(a_push_grows, in_fire && !is_full && (op_i == dqir_pkg::OP_PUSH_FRONT || op_i == dqir_pkg::OP_PUSH_BACK), count_q == $past(count_q) + CntW'(1), "push did not grow the deque")
  `DQIR_ASSERT_NEXT(a_pop_shrinks, in_fire && !is_empty && op_i == dqir_pkg::OP_POP_FRONT, count_q == $past(count_q) - CntW'(1), "pop front did not shrink the deque")

endmodule
